>>> hw/rtl/flmb_pkg.sv
`timescale 1ns / 1ps

package flmb_pkg;

	localparam int TABLE_ENTRIES_DEF = 256;

	// item kinds
	localparam logic [1:0] KIND_START  = 2'd0;
	localparam logic [1:0] KIND_HEADER = 2'd1;
	localparam logic [1:0] KIND_FINISH = 2'd2;
	localparam logic [1:0] KIND_LOOKUP = 2'd3;

	// header actions
	localparam logic [2:0] ACT_IGNORED = 3'd0;
	localparam logic [2:0] ACT_BEYOND  = 3'd1;
	localparam logic [2:0] ACT_NEW     = 3'd2;
	localparam logic [2:0] ACT_REPLACE = 3'd3;
	localparam logic [2:0] ACT_OLDER   = 3'd4;
	localparam logic [2:0] ACT_BAD     = 3'd5;

	// config register indexes
	localparam logic [2:0] REG_TARGET_VOL  = 3'd0;
	localparam logic [2:0] REG_LAYOUT_MODE = 3'd1;
	localparam logic [2:0] REG_USABLE      = 3'd2;
	localparam logic [2:0] REG_LAYOUT_LEN  = 3'd3;
	localparam logic [2:0] REG_HIGHEST     = 3'd4;

	typedef struct packed {
		logic [7:0]  blk;
		logic [63:0] seq;
		logic [23:0] len;
		logic [23:0] size;
	} entry_t;

	typedef struct packed {
		logic capture; // request accepted: latch fields, start map read
		logic exec;    // evaluate start, header or lookup and load result
		logic mul;     // finish: register expected-length product
		logic fin;     // finish: compare and load result
	} ctl_cmd_t;

	typedef struct packed {
		logic [1:0] kind;
		logic       out_free;
	} ctl_sts_t;

endpackage

>>> hw/rtl/flmb_ctrl.sv
`timescale 1ns / 1ps

module flmb_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  flmb_pkg::ctl_sts_t  sts,
	output flmb_pkg::ctl_cmd_t  cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (sts.kind == flmb_pkg::KIND_FINISH) begin
					cmd.mul = 1'b1;
					state_d = ST_FIN;
				end else if (sts.out_free) begin
					cmd.exec = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_FIN: begin
				if (sts.out_free) begin
					cmd.fin = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign in_ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> hw/rtl/flmb_datapath.sv
`timescale 1ns / 1ps

module flmb_datapath #(
	parameter int TABLE_ENTRIES = flmb_pkg::TABLE_ENTRIES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  flmb_pkg::ctl_cmd_t cmd,
	output flmb_pkg::ctl_sts_t sts,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic [1:0]         kind,
	input  logic [7:0]         physical_index,
	input  logic               header_good,
	input  logic [31:0]        volume_of_block,
	input  logic [31:0]        logical_number,
	input  logic [63:0]        sequence_number,
	input  logic [23:0]        payload_bytes,
	input  logic [31:0]        blocks_in_volume,
	input  logic               payload_good,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0]         action,
	output logic               volume_ok,
	output logic [30:0]        total_bytes,
	output logic               entry_valid,
	output logic [7:0]         entry_physical
);

	localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CW = AW + 1;
	localparam int PW = 24 + AW;
	localparam int EW = (PW + 1 > 32) ? PW + 1 : 32;
	localparam logic [31:0] TOP_IDX = 32'(TABLE_ENTRIES - 1);
	localparam logic [31:0] N_ENT   = 32'(TABLE_ENTRIES);

	// config
	logic [31:0] target_q;
	logic        layout_q;
	logic [23:0] usable_q;
	logic [14:0] layout_len_q;
	logic [7:0]  highest_q;

	// latched request
	logic [1:0]  kind_q;
	logic [7:0]  phys_q;
	logic        hgood_q;
	logic [31:0] vol_q;
	logic [31:0] lnum_q;
	logic [63:0] seq_q;
	logic [23:0] size_q;
	logic [31:0] blocks_q;
	logic        pgood_q;

	// scan state
	flmb_pkg::entry_t       map_q [TABLE_ENTRIES];
	flmb_pkg::entry_t       rd_q;
	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [CW-1:0]          good_q;
	logic [31:0]            total_q;
	logic                   claimed_set_q;
	logic [31:0]            claimed_q;

	// finish pipeline
	logic [PW-1:0] prod_q;
	logic          fin_try_q;
	logic          fin_cond_q;
	logic          fin_fallback_q;

	logic          out_valid_q;

	logic [AW-1:0] idx;
	logic [AW-1:0] last_idx;
	logic [AW-1:0] rd_addr;
	logic [31:0]   lim;
	logic [31:0]   last32;
	logic          vb;
	logic          hdr_take;
	logic          beyond;
	logic          older;
	logic          commit;
	logic [2:0]    hdr_act;
	logic [23:0]   len24;
	logic [31:0]   total_d;
	logic          lk_valid;
	logic          cond_a;
	logic          last_ok;
	logic [PW-1:0] prod_c;
	logic [EW-1:0] expected;
	flmb_pkg::entry_t wr_entry;

	assign idx      = lnum_q[AW-1:0];
	assign last32   = claimed_q - 32'd1;
	assign last_idx = last32[AW-1:0];
	assign rd_addr  = (kind == flmb_pkg::KIND_FINISH) ? last_idx : logical_number[AW-1:0];
	assign lim      = ({24'd0, highest_q} > TOP_IDX) ? TOP_IDX : {24'd0, highest_q};

	// header evaluation
	assign vb       = valid_q[idx];
	assign hdr_take = hgood_q && (vol_q == target_q);
	assign beyond   = lnum_q > lim;
	assign older    = vb && (seq_q < rd_q.seq);
	assign commit   = hdr_take && !beyond && !older && pgood_q;
	assign len24    = layout_q ? {9'd0, layout_len_q} : size_q;

	always_comb begin
		priority if (!hdr_take) begin
			hdr_act = flmb_pkg::ACT_IGNORED;
		end else if (beyond) begin
			hdr_act = flmb_pkg::ACT_BEYOND;
		end else if (older) begin
			hdr_act = flmb_pkg::ACT_OLDER;
		end else if (!pgood_q) begin
			hdr_act = flmb_pkg::ACT_BAD;
		end else if (vb) begin
			hdr_act = flmb_pkg::ACT_REPLACE;
		end else begin
			hdr_act = flmb_pkg::ACT_NEW;
		end
	end

	always_comb begin
		unique case (kind_q)
			flmb_pkg::KIND_START:  total_d = 32'd0;
			flmb_pkg::KIND_HEADER: begin
				if (commit) begin
					total_d = total_q - (vb ? {8'd0, rd_q.len} : 32'd0) + {8'd0, len24};
				end else begin
					total_d = total_q;
				end
			end
			default:               total_d = total_q;
		endcase
	end

	assign lk_valid = (lnum_q < N_ENT) && vb;

	// finish evaluation
	assign cond_a   = (total_q != 32'd0) && claimed_set_q && (claimed_q != 32'd0) &&
		({{(32 - CW){1'b0}}, good_q} == claimed_q);
	assign last_ok  = (last32 < N_ENT) && valid_q[last_idx];
	assign prod_c   = PW'(usable_q) * PW'(last_idx);
	assign expected = EW'(prod_q) + EW'(rd_q.size);

	assign wr_entry.blk  = phys_q;
	assign wr_entry.seq  = seq_q;
	assign wr_entry.len  = len24;
	assign wr_entry.size = size_q;

	// config port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q     <= '0;
			layout_q     <= 1'b0;
			usable_q     <= '0;
			layout_len_q <= '0;
			highest_q    <= 8'hFF;
		end else if (cfg_we) begin
			unique case (cfg_index)
				flmb_pkg::REG_TARGET_VOL:  target_q     <= cfg_data;
				flmb_pkg::REG_LAYOUT_MODE: layout_q     <= cfg_data[0];
				flmb_pkg::REG_USABLE:      usable_q     <= cfg_data[23:0];
				flmb_pkg::REG_LAYOUT_LEN:  layout_len_q <= cfg_data[14:0];
				flmb_pkg::REG_HIGHEST:     highest_q    <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	// request latch and map memory
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q   <= kind;
			phys_q   <= physical_index;
			hgood_q  <= header_good;
			vol_q    <= volume_of_block;
			lnum_q   <= logical_number;
			seq_q    <= sequence_number;
			size_q   <= payload_bytes;
			blocks_q <= blocks_in_volume;
			pgood_q  <= payload_good;
			rd_q     <= map_q[rd_addr];
		end
		if (cmd.exec && (kind_q == flmb_pkg::KIND_HEADER) && commit) begin
			map_q[idx] <= wr_entry;
		end
		if (cmd.mul) begin
			prod_q         <= prod_c;
			fin_try_q      <= last_ok;
			fin_cond_q     <= cond_a;
			fin_fallback_q <= layout_q && (good_q != '0);
		end
	end

	// scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q       <= '0;
			good_q        <= '0;
			total_q       <= '0;
			claimed_set_q <= 1'b0;
			claimed_q     <= '0;
		end else if (cmd.exec) begin
			total_q <= total_d;
			if (kind_q == flmb_pkg::KIND_START) begin
				valid_q       <= '0;
				good_q        <= '0;
				claimed_set_q <= 1'b0;
			end else if ((kind_q == flmb_pkg::KIND_HEADER) && commit) begin
				valid_q[idx]  <= 1'b1;
				good_q        <= good_q + CW'(!vb);
				claimed_set_q <= 1'b1;
				claimed_q     <= blocks_q;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.exec || cmd.fin) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			action         <= (kind_q == flmb_pkg::KIND_HEADER) ? hdr_act
				: flmb_pkg::ACT_IGNORED;
			volume_ok      <= 1'b0;
			total_bytes    <= total_d[31] ? 31'h7FFF_FFFF : total_d[30:0];
			entry_valid    <= (kind_q == flmb_pkg::KIND_LOOKUP) && lk_valid;
			entry_physical <= ((kind_q == flmb_pkg::KIND_LOOKUP) && lk_valid) ? rd_q.blk
				: 8'd0;
		end else if (cmd.fin) begin
			action         <= flmb_pkg::ACT_IGNORED;
			volume_ok      <= fin_cond_q ? (fin_try_q && (expected == EW'(total_q)))
				: fin_fallback_q;
			total_bytes    <= total_q[31] ? 31'h7FFF_FFFF : total_q[30:0];
			entry_valid    <= 1'b0;
			entry_physical <= 8'd0;
		end
	end

	assign out_valid    = out_valid_q;
	assign sts.kind     = kind_q;
	assign sts.out_free = !out_valid_q || out_ready;

endmodule

>>> hw/rtl/flash_leb_map_builder_core.sv
`timescale 1ns / 1ps
// Start, header and lookup results are loaded by the evaluate step after the capture and map read;
//   finish results by the compare step, after an extra step for the expected-length multiply.
// A new request is taken only once the previous one has loaded its result: the registered
//   map-memory read is followed by the read-modify-write of one entry.
// Reset (arst_n low): map empty, counters cleared, config at defaults, no result pending.

module flash_leb_map_builder_core #(
	parameter int TABLE_ENTRIES = flmb_pkg::TABLE_ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// config write port
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	// request channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  kind,
	input  logic [7:0]  physical_index,
	input  logic        header_good,
	input  logic [31:0] volume_of_block,
	input  logic [31:0] logical_number,
	input  logic [63:0] sequence_number,
	input  logic [23:0] payload_bytes,
	input  logic [31:0] blocks_in_volume,
	input  logic        payload_good,
	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  action,
	output logic        volume_ok,
	output logic [30:0] total_bytes,
	output logic        entry_valid,
	output logic [7:0]  entry_physical
);

	// The controller sequences each request: capture + map read, then either the
	// evaluate/update step or, for finish, a multiply step and a compare step.
	// A result waiting in the output register does not block the next request;
	// it only holds back the step that would overwrite it.
	flmb_pkg::ctl_cmd_t cmd;
	flmb_pkg::ctl_sts_t sts;

	flmb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Datapath: config registers, map memory (one registered read port, one write
	// port), per-entry valid flops, good count, byte total and the result register.
	flmb_datapath #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.kind             (kind),
		.physical_index   (physical_index),
		.header_good      (header_good),
		.volume_of_block  (volume_of_block),
		.logical_number   (logical_number),
		.sequence_number  (sequence_number),
		.payload_bytes    (payload_bytes),
		.blocks_in_volume (blocks_in_volume),
		.payload_good     (payload_good),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.action           (action),
		.volume_ok        (volume_ok),
		.total_bytes      (total_bytes),
		.entry_valid      (entry_valid),
		.entry_physical   (entry_physical)
	);

endmodule

>>> hw/rtl/flmb_checker.sv
`timescale 1ns / 1ps

module flmb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  action,
	input logic        volume_ok,
	input logic [30:0] total_bytes,
	input logic        entry_valid,
	input logic [7:0]  entry_physical
);

	// one request in flight: ready drops after a request is taken
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("request taken while previous one still in work");

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(action) && $stable(volume_ok)
			&& $stable(total_bytes) && $stable(entry_valid) && $stable(entry_physical)))
		else $error("stalled result changed");

	// a header action never comes with finish or lookup results
	a_kind_excl: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (action != flmb_pkg::ACT_IGNORED)) |-> (!volume_ok && !entry_valid))
		else $error("header action mixed with finish or lookup result");

	// invalid lookup reads as physical zero
	a_phys_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !entry_valid) |-> (entry_physical == 8'd0))
		else $error("physical index shown for invalid entry");

endmodule

bind flash_leb_map_builder_core flmb_checker u_flmb_checker (.*);
